FILE: rtl/uhm_pkg.sv
// Package with the shared types and constants of the utilization monitor.
`timescale 1ns / 1ps

package uhm_pkg;

  localparam int unsigned NUM_BUSY  = 3;
  localparam int unsigned NUM_LOADS = 4;
  localparam int unsigned LOAD_W    = 7;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned PROD_W    = TOTAL_W + LOAD_W;
  localparam int unsigned CH_W      = 2;
  localparam int unsigned BIT_W     = 3;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [LOAD_W-1:0] PERCENT       = 7'd100;
  localparam logic [LOAD_W-1:0] THRESHOLD_RST = 7'd1;

  localparam logic [0:0] REG_IDX_THRESHOLD = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

FILE: rtl/utilization_monitor_hysteresis_top.sv
// Top level of the utilization monitor with hysteresis on the reported loads.
//
//   Channel   Signals                               Direction   Moves
//   in        in_valid_i / in_ready_o + 5 fields    inbound     one sample
//   out       out_valid_o / out_ready_i + 8 fields  outbound    one load report
//   cfg       psel / penable / pwrite / paddr ...   inbound     threshold register
//
// A new sample is accepted only once the previous one has been through all steps and
// the block is back in idle; each channel that is not skipped is divided on one
// shared 39-bit restoring subtractor that yields one quotient bit per cycle.
// Reset is asynchronous and active low and clears all history and the threshold to 1.
// A waiting result holds the block in its final step until the output transfer.
`timescale 1ns / 1ps

module utilization_monitor_hysteresis_top
  import uhm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TOTAL_W-1:0]   sample_time_i,
  input  logic [LOAD_W-1:0]    sched_load_i,
  input  logic [TOTAL_W-1:0]   accel_busy_total_i,
  input  logic [TOTAL_W-1:0]   core0_busy_total_i,
  input  logic [TOTAL_W-1:0]   core1_busy_total_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LOAD_W-1:0]    sched_load_pct_o,
  output logic [LOAD_W-1:0]    accel_load_pct_o,
  output logic [LOAD_W-1:0]    core0_load_pct_o,
  output logic [LOAD_W-1:0]    core1_load_pct_o,
  output logic                 sched_report_o,
  output logic                 accel_report_o,
  output logic                 core0_report_o,
  output logic                 core1_report_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  state_e               state_q, state_d;
  logic [LOAD_W-1:0]    thr_q;
  logic [TOTAL_W-1:0]   last_time_q;
  logic [TOTAL_W-1:0]   last_busy_q [NUM_BUSY];
  logic [LOAD_W-1:0]    last_rep_q [NUM_LOADS];
  logic [TOTAL_W-1:0]   cur_q [NUM_BUSY];
  logic [TOTAL_W-1:0]   dt_q;
  logic [LOAD_W-1:0]    sched_q;
  logic [LOAD_W-1:0]    loads_q [NUM_BUSY];
  logic [CH_W-1:0]      ch_q;
  logic [BIT_W-1:0]     bit_q;
  logic [PROD_W-1:0]    rem_q;
  logic [PROD_W-1:0]    dsr_q;
  logic [LOAD_W-1:0]    quo_q;
  logic                 out_valid_q;
  logic [LOAD_W-1:0]    out_load_q [NUM_LOADS];
  logic [NUM_LOADS-1:0] out_rep_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 cfg_write;
  logic                 ch_last;
  logic [TOTAL_W-1:0]   busy;
  logic                 skip;
  logic [PROD_W:0]      trial;
  logic                 bit_ok;
  logic [LOAD_W-1:0]    all_load [NUM_LOADS];
  logic [LOAD_W-1:0]    diff [NUM_LOADS];
  logic [NUM_LOADS-1:0] rep;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign cfg_write = psel && penable && pwrite && pready;
  assign ch_last   = (ch_q == CH_W'(NUM_BUSY - 1));

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_THRESHOLD) ? {{(DATA_W-LOAD_W){1'b0}}, thr_q}
                                                  : '0;

  assign busy   = cur_q[ch_q] - last_busy_q[ch_q];
  assign skip   = (cur_q[ch_q] < last_busy_q[ch_q]) || (dt_q == '0) || (busy > dt_q);
  assign trial  = {1'b0, rem_q} - {1'b0, dsr_q};
  assign bit_ok = !trial[PROD_W];

  always_comb begin
    all_load[0] = sched_q;
    for (int i = 0; i < NUM_BUSY; i++) begin
      all_load[i+1] = loads_q[i];
    end
    for (int i = 0; i < NUM_LOADS; i++) begin
      diff[i] = (all_load[i] > last_rep_q[i]) ? all_load[i] - last_rep_q[i]
                                              : last_rep_q[i] - all_load[i];
      rep[i]  = diff[i] > thr_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!skip) begin
          state_d = ST_DIV;
        end else if (ch_last) begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (bit_q == '0) begin
          state_d = ch_last ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= THRESHOLD_RST;
      last_time_q <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_BUSY; i++) begin
        last_busy_q[i] <= '0;
      end
      for (int i = 0; i < NUM_LOADS; i++) begin
        last_rep_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_write && paddr[2] == REG_IDX_THRESHOLD) begin
        thr_q <= pwdata[LOAD_W-1:0];
      end
      if (in_fire) begin
        last_time_q <= sample_time_i;
        ch_q        <= '0;
      end
      if (state_q == ST_LOAD) begin
        last_busy_q[ch_q] <= cur_q[ch_q];
        if (skip) begin
          ch_q <= ch_q + 1'b1;
        end
      end
      if (state_q == ST_DIV && bit_q == '0) begin
        ch_q <= ch_q + 1'b1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < NUM_LOADS; i++) begin
          if (rep[i]) begin
            last_rep_q[i] <= all_load[i];
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q     <= sample_time_i - last_time_q;
      sched_q  <= sched_load_i;
      cur_q[0] <= accel_busy_total_i;
      cur_q[1] <= core0_busy_total_i;
      cur_q[2] <= core1_busy_total_i;
    end
    case (state_q)
      ST_LOAD: begin
        rem_q <= PROD_W'(busy) * PROD_W'(PERCENT);
        dsr_q <= {1'b0, dt_q, {(LOAD_W-1){1'b0}}};
        bit_q <= BIT_W'(LOAD_W - 1);
        quo_q <= '0;
        if (skip) begin
          loads_q[ch_q] <= '0;
        end
      end
      ST_DIV: begin
        if (bit_ok) begin
          rem_q <= trial[PROD_W-1:0];
        end
        dsr_q <= dsr_q >> 1;
        bit_q <= bit_q - 1'b1;
        quo_q <= {quo_q[LOAD_W-2:0], bit_ok};
        if (bit_q == '0) begin
          loads_q[ch_q] <= {quo_q[LOAD_W-2:0], bit_ok};
        end
      end
      ST_FIN: begin
        if (out_free) begin
          for (int i = 0; i < NUM_LOADS; i++) begin
            out_load_q[i] <= all_load[i];
          end
          out_rep_q <= rep;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign sched_load_pct_o = out_load_q[0];
  assign accel_load_pct_o = out_load_q[1];
  assign core0_load_pct_o = out_load_q[2];
  assign core1_load_pct_o = out_load_q[3];
  assign sched_report_o   = out_rep_q[0];
  assign accel_report_o   = out_rep_q[1];
  assign core0_report_o   = out_rep_q[2];
  assign core1_report_o   = out_rep_q[3];

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("Block stayed ready after an input transfer.");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> (state_q == ST_FIN))
    else $error("Result step left while the output register was still full.");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_DIV) |-> (ch_q < CH_W'(NUM_BUSY)))
    else $error("Channel counter ran past the last busy channel.");

  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accel_load_pct_o <= PERCENT && core0_load_pct_o <= PERCENT &&
                     core1_load_pct_o <= PERCENT))
    else $error("Computed load exceeds one hundred percent.");
`endif

endmodule
